/* design/audio_noise_gate_assert.svh */
// ----------------------------------------------------------------------------
// Noise gate assertion macros
// Concurrent assertion wrappers on clk with rst as disable.
// ----------------------------------------------------------------------------
`ifndef AUDIO_NOISE_GATE_ASSERT_SVH
`define AUDIO_NOISE_GATE_ASSERT_SVH
`ifndef SYNTHESIS
`define ANG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ANG_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ANG_ASSERT(label, prop, msg)
`define ANG_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

/* design/ang_pkg.sv */
// ----------------------------------------------------------------------------
// Noise gate package
// Field widths, fixed-point constants, register indexes and channel state.
// ----------------------------------------------------------------------------
package ang_pkg;

  localparam int CH_FIELD_W  = 3;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int THR_W       = 15;
  localparam int HOLD_W      = 20;
  localparam int RUN_W       = 21;
  localparam int GAIN_W      = 32;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = 32'h8000_0000;
  localparam logic [GAIN_W-1:0] STEP_UNITY = 32'h4000_0000;
  localparam logic [GAIN_W-1:0] GAIN_FLOOR = 32'd2147;
  localparam logic [RUN_W-1:0]  RUN_MAX    = '1;

  localparam logic [THR_W-1:0]  THRESHOLD_RST = 15'd1966;
  localparam logic [HOLD_W-1:0] HOLD_RST      = 20'd441;
  localparam logic [GAIN_W-1:0] ATTACK_RST    = 32'd1073849198;
  localparam logic [GAIN_W-1:0] RELEASE_RST   = 32'd1073634450;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_OPEN_THRESHOLD = 8'd0,
    REG_HOLD_SAMPLES   = 8'd1,
    REG_ATTACK_GAIN    = 8'd2,
    REG_RELEASE_GAIN   = 8'd3
  } reg_index_t;

  typedef struct packed {
    logic              closed;
    logic [RUN_W-1:0]  run;
    logic [GAIN_W-1:0] gain;
    logic [GAIN_W-1:0] step;
  } chan_state_t;

endpackage

/* design/ang_in_if.sv */
// ----------------------------------------------------------------------------
// Noise gate sample channel
// Valid/ready channel carrying a channel number and a signed sample.
// ----------------------------------------------------------------------------
interface ang_in_if #(parameter int SAMPLE_BITS = 16);
  import ang_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [CH_FIELD_W-1:0]         channel;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  modport source(output valid, channel, sample_in, input ready);
  modport sink(input valid, channel, sample_in, output ready);
endinterface

/* design/ang_out_if.sv */
// ----------------------------------------------------------------------------
// Noise gate result channel
// Valid/ready channel carrying the gated sample and the gate state.
// ----------------------------------------------------------------------------
interface ang_out_if #(parameter int SAMPLE_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          gate_closed;
  modport source(output valid, sample_out, gate_closed, input ready);
  modport sink(input valid, sample_out, gate_closed, output ready);
endinterface

/* design/ang_cfg_if.sv */
// ----------------------------------------------------------------------------
// Noise gate configuration channel
// Valid/ready register write channel carrying an index and write data.
// ----------------------------------------------------------------------------
interface ang_cfg_if;
  import ang_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [CFG_DATA_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* design/audio_noise_gate.sv */
// ----------------------------------------------------------------------------
// Audio noise gate
// Per-channel gate with hold, attack and release over interleaved samples.
// ----------------------------------------------------------------------------
// Takes one item per cycle unless the result output stalls; each item passes
// through an input register, then the update in which the channel state
// is read, updated and written back while the result register loads.
// Channel state lives in flip-flops, so items of the same channel may follow
// each other back to back. The update cycle holds a SAMPLE_BITS x 32
// multiplier (sample times gain) beside a 32x32 multiplier (gain times the
// selected step), followed by the clamp.
// Register writes take effect from the next item.
`include "audio_noise_gate_assert.svh"

module audio_noise_gate #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  ang_in_if.sink     din,
  ang_out_if.source  dout,
  ang_cfg_if.sink    cfg
);
  import ang_pkg::*;

  localparam int IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXT_W  = 7;
  localparam int CMP_W  = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;
  localparam int PROD_W = SAMPLE_BITS + GAIN_W;
  localparam int GP_W   = 2 * GAIN_W;

  logic [THR_W-1:0]  open_threshold;
  logic [HOLD_W-1:0] hold_samples;
  logic [GAIN_W-1:0] attack_gain;
  logic [GAIN_W-1:0] release_gain;

  logic                          s1_valid;
  logic [CH_FIELD_W-1:0]         s1_channel;
  logic signed [SAMPLE_BITS-1:0] s1_sample;
  logic                          s1_fire;

  logic                          out_valid;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          out_closed;

  chan_state_t st [CHANNELS];

  logic [EXT_W-1:0]       ch_ext;
  logic                   in_range;
  logic [IDX_W-1:0]       idx;
  logic                   neg;
  logic [SAMPLE_BITS-1:0] mag;
  logic [PROD_W-1:0]      prod_out;
  logic [SAMPLE_BITS-1:0] scaled;
  logic [SAMPLE_BITS-1:0] gated;
  logic                   quiet;
  logic                   loud;
  chan_state_t            cur;
  chan_state_t            nxt;
  logic [GP_W-1:0]        prod_gain;
  logic [GP_W-31:0]       g;

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      open_threshold <= THRESHOLD_RST;
      hold_samples   <= HOLD_RST;
      attack_gain    <= ATTACK_RST;
      release_gain   <= RELEASE_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_OPEN_THRESHOLD: open_threshold <= cfg.data[THR_W-1:0];
        REG_HOLD_SAMPLES:   hold_samples   <= cfg.data[HOLD_W-1:0];
        REG_ATTACK_GAIN:    attack_gain    <= cfg.data[GAIN_W-1:0];
        REG_RELEASE_GAIN:   release_gain   <= cfg.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign s1_fire  = s1_valid && (!out_valid || dout.ready);
  assign din.ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      s1_channel <= din.channel;
      s1_sample  <= din.sample_in;
    end
  end

  // per-channel update
  assign ch_ext   = EXT_W'(s1_channel);
  assign in_range = ch_ext < EXT_W'(CHANNELS);
  assign idx      = ch_ext[IDX_W-1:0];
  assign cur      = st[idx];

  assign neg      = s1_sample[SAMPLE_BITS-1];
  assign mag      = neg ? (~s1_sample + 1'b1) : s1_sample;
  assign prod_out = PROD_W'(mag) * PROD_W'(cur.gain);
  assign scaled   = prod_out[SAMPLE_BITS+30:31];
  assign gated    = neg ? (~scaled + 1'b1) : scaled;

  assign quiet = CMP_W'(mag) < CMP_W'(open_threshold);
  assign loud  = CMP_W'(mag) > CMP_W'(open_threshold);

  always_comb begin
    nxt = cur;
    if (!cur.closed && quiet) begin
      if (cur.run == RUN_W'(hold_samples)) begin
        nxt.closed = 1'b1;
        nxt.step   = release_gain;
      end
      if (cur.run != RUN_MAX) begin
        nxt.run = cur.run + 1'b1;
      end
    end else begin
      nxt.run = '0;
    end
    if (nxt.closed && loud) begin
      nxt.closed = 1'b0;
      nxt.step   = attack_gain;
    end
    prod_gain = GP_W'(cur.gain) * GP_W'(nxt.step);
    g         = prod_gain[GP_W-1:30];
    priority if (g < (GP_W-30)'(GAIN_FLOOR)) begin
      nxt.gain = GAIN_FLOOR;
    end else if (g > (GP_W-30)'(GAIN_UNITY)) begin
      nxt.gain = GAIN_UNITY;
    end else begin
      nxt.gain = g[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        st[i] <= '{closed: 1'b0, run: '0, gain: GAIN_UNITY, step: STEP_UNITY};
      end
    end else if (s1_fire && in_range) begin
      st[idx] <= nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_sample <= in_range ? gated : s1_sample;
      out_closed <= in_range && nxt.closed;
    end
  end

  assign dout.valid       = out_valid;
  assign dout.sample_out  = out_sample;
  assign dout.gate_closed = out_closed;

  `ANG_ASSERT_NEXT(a_item_to_result, s1_fire, out_valid, "registered item lost")
  `ANG_ASSERT(a_ready_when_empty, s1_valid || din.ready, "input stalled while empty")
  `ANG_ASSERT(a_gain_clamped,
              !(s1_fire && in_range) || (nxt.gain >= GAIN_FLOOR && nxt.gain <= GAIN_UNITY),
              "gain out of range")
  `ANG_ASSERT(a_close_on_hold,
              !(s1_fire && in_range && !cur.closed && nxt.closed) ||
              (quiet && cur.run == RUN_W'(hold_samples)),
              "gate closed early")

endmodule

/* sim/audio_noise_gate_tb.sv */
// ----------------------------------------------------------------------------
// Audio noise gate testbench
// Drives interleaved samples and register writes with random idle cycles on
// the sample and result channels. Every result is checked in order against a
// per-channel gain and gate predictor, or against its typed directed row.
// ----------------------------------------------------------------------------
module audio_noise_gate_tb;
  import ang_pkg::*;

  localparam int SAMPLE_W        = 16;
  localparam int NUM_CH          = 8;
  localparam int PHASES          = 9;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int LONG_STALL      = 200;
  localparam int TIMEOUT_CYCLES  = 600_000;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 8'd4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       gate_closed;
  } result_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CFG_INDEX_W-1:0]     addr;
    logic [CFG_DATA_W-1:0]      value;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] exp_out;
    logic                       exp_closed;
  } row_t;

  localparam row_t DIRECTED [26] = '{
    '{ROW_SAMPLE, 8'd0, 32767,  1'b1, 16'sd32767,  1'b0},
    '{ROW_SAMPLE, 8'd1, -32768, 1'b1, -16'sd32768, 1'b0},
    '{ROW_SAMPLE, 8'd2, 0,      1'b1, 16'sd0,      1'b0},
    '{ROW_SAMPLE, 8'd3, -1,     1'b1, -16'sd1,     1'b0},
    '{ROW_SAMPLE, 8'd4, 1966,   1'b1, 16'sd1966,   1'b0},
    '{ROW_SAMPLE, 8'd7, -1967,  1'b1, -16'sd1967,  1'b0},
    '{ROW_WRITE,  REG_SPARE,          32'hFFFF_FFFF, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE,  REG_HOLD_SAMPLES,   32'd0,         1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE,  REG_OPEN_THRESHOLD, 32'd100,       1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE,  REG_RELEASE_GAIN,   32'h2000_0000, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE,  REG_ATTACK_GAIN,    32'hFFFF_FFFF, 1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 8'd0, 5,      1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 8'd0, 32767,  1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 8'd0, -100,   1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 8'd0, -101,   1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 8'd0, -32768, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE,  REG_RELEASE_GAIN,   32'd0,         1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 8'd5, -3,     1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 8'd5, 12345,  1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 8'd5, -32768, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE,  REG_OPEN_THRESHOLD, 32'd32767,     1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE,  REG_HOLD_SAMPLES,   32'd1048575,   1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 8'd6, 32767,  1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 8'd6, -32768, 1'b0, 16'sd0, 1'b0},
    '{ROW_WRITE,  REG_OPEN_THRESHOLD, 32'd0,         1'b0, 16'sd0, 1'b0},
    '{ROW_SAMPLE, 8'd6, 0,      1'b0, 16'sd0, 1'b0}
  };

  logic clk;
  logic rst;

  ang_in_if  #(.SAMPLE_BITS(SAMPLE_W)) din_if ();
  ang_out_if #(.SAMPLE_BITS(SAMPLE_W)) dout_if ();
  ang_cfg_if cfg_if ();

  audio_noise_gate #(
    .CHANNELS   (NUM_CH),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk (clk),
    .rst (rst),
    .din (din_if),
    .dout(dout_if),
    .cfg (cfg_if)
  );

  logic [THR_W-1:0]  thr_cfg;
  logic [HOLD_W-1:0] hold_cfg;
  logic [GAIN_W-1:0] attack_cfg;
  logic [GAIN_W-1:0] release_cfg;
  logic [RUN_W-1:0]  run_q    [NUM_CH];
  logic              closed_q [NUM_CH];
  logic [GAIN_W-1:0] gain_q   [NUM_CH];
  logic [GAIN_W-1:0] step_q   [NUM_CH];

  result_t     pending_q [$];
  bit          failed;
  bit          cfg_busy;
  bit          steady;
  bit          long_stall_req;
  int unsigned cycle_count;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic result_t predict_gated_sample(logic [2:0] ch,
                                                   logic signed [SAMPLE_W-1:0] s);
    result_t     r;
    logic        neg;
    logic [16:0] mag;
    logic [63:0] scaled;
    logic [63:0] next_gain;
    neg    = s[SAMPLE_W-1];
    mag    = neg ? 17'(-{1'b1, s}) : {1'b0, s};
    scaled = (64'(mag) * 64'(gain_q[ch])) >> 31;
    r.sample_out = neg ? -scaled[15:0] : scaled[15:0];
    if (!closed_q[ch] && mag < 17'(thr_cfg)) begin
      if (run_q[ch] == RUN_W'(hold_cfg)) begin
        closed_q[ch] = 1'b1;
        step_q[ch]   = release_cfg;
      end
      if (run_q[ch] != RUN_MAX) run_q[ch] = run_q[ch] + 1'b1;
    end else begin
      run_q[ch] = '0;
    end
    if (closed_q[ch] && mag > 17'(thr_cfg)) begin
      closed_q[ch] = 1'b0;
      step_q[ch]   = attack_cfg;
    end
    next_gain = (64'(gain_q[ch]) * 64'(step_q[ch])) >> 30;
    if (next_gain < 64'(GAIN_FLOOR)) next_gain = 64'(GAIN_FLOOR);
    else if (next_gain > 64'(GAIN_UNITY)) next_gain = 64'(GAIN_UNITY);
    gain_q[ch]    = next_gain[31:0];
    r.gate_closed = closed_q[ch];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] draw_sample(int quiet_pct);
    int r;
    int mag;
    r = $urandom_range(0, 99);
    if (r < quiet_pct && thr_cfg != 0) mag = $urandom_range(0, int'(thr_cfg) - 1);
    else if (r < quiet_pct + 5) mag = int'(thr_cfg);
    else if (r < 90) mag = $urandom_range(int'(thr_cfg) + 1, 32768);
    else return SAMPLE_W'($urandom);
    if (mag == 32768 || (mag != 0 && $urandom_range(0, 1) == 1)) return SAMPLE_W'(-mag);
    return SAMPLE_W'(mag);
  endfunction

  task automatic wait_drained();
    din_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    if (!cfg_busy) begin
      wait_drained();
      cfg_busy = 1'b1;
    end
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_OPEN_THRESHOLD: thr_cfg     = val[THR_W-1:0];
      REG_HOLD_SAMPLES:   hold_cfg    = val[HOLD_W-1:0];
      REG_ATTACK_GAIN:    attack_cfg  = val;
      REG_RELEASE_GAIN:   release_cfg = val;
      default: ;
    endcase
  endtask

  task automatic push_sample(logic [2:0] ch, logic signed [SAMPLE_W-1:0] s, int gap,
                             bit typed, result_t typed_res);
    result_t r;
    if (cfg_busy) begin
      cfg_if.valid <= 1'b0;
      cfg_busy = 1'b0;
    end
    if (gap > 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_if.valid     <= 1'b1;
    din_if.channel   <= ch;
    din_if.sample_in <= s;
    do @(posedge clk); while (!din_if.ready);
    r = predict_gated_sample(ch, s);
    pending_q.push_back(typed ? typed_res : r);
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected item: sample_out %0d gate_closed %0b",
               dout_if.sample_out, dout_if.gate_closed);
        failed = 1'b1;
      end else begin
        want = pending_q.pop_front();
        if (dout_if.sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, got %0d", want.sample_out, dout_if.sample_out);
          failed = 1'b1;
        end
        if (dout_if.gate_closed !== want.gate_closed) begin
          $error("gate_closed: expected %0b, got %0b", want.gate_closed,
                 dout_if.gate_closed);
          failed = 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TIMEOUT_CYCLES) begin
      $display("audio_noise_gate verification failed");
      $finish;
    end
  end

  initial begin
    dout_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        dout_if.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else if (steady || $urandom_range(0, 3) != 0) begin
        dout_if.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        dout_if.ready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end
    end
  end

  initial begin
    logic [2:0] fav [3];
    int         quiet_pct;
    int         gap;
    logic [2:0] ch;
    logic [CFG_DATA_W-1:0] val;
    rst              <= 1'b1;
    din_if.valid     <= 1'b0;
    din_if.channel   <= '0;
    din_if.sample_in <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= '0;
    cfg_if.data      <= '0;
    cycle_count      = 0;
    failed           = 1'b0;
    cfg_busy         = 1'b0;
    steady           = 1'b0;
    long_stall_req   = 1'b0;
    thr_cfg          = THRESHOLD_RST;
    hold_cfg         = HOLD_RST;
    attack_cfg       = ATTACK_RST;
    release_cfg      = RELEASE_RST;
    for (int c = 0; c < NUM_CH; c++) begin
      run_q[c]    = '0;
      closed_q[c] = 1'b0;
      gain_q[c]   = GAIN_UNITY;
      step_q[c]   = STEP_UNITY;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < $size(DIRECTED); i++) begin
      gap = ($urandom_range(0, 2) == 0) ? idle_len() : 0;
      if (DIRECTED[i].kind == ROW_WRITE) begin
        write_reg(DIRECTED[i].addr, DIRECTED[i].value);
      end else begin
        push_sample(DIRECTED[i].addr[2:0], DIRECTED[i].value[SAMPLE_W-1:0], gap,
                    DIRECTED[i].typed, '{DIRECTED[i].exp_out, DIRECTED[i].exp_closed});
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      case ($urandom_range(0, 9))
        0:       val = 0;
        1:       val = 32767;
        2:       val = $urandom_range(0, 32767);
        default: val = $urandom_range(1, 3000);
      endcase
      write_reg(REG_OPEN_THRESHOLD, val);
      case ($urandom_range(0, 9))
        0:       val = 0;
        1:       val = 1048575;
        2:       val = CFG_DATA_W'(HOLD_RST);
        default: val = $urandom_range(0, 16);
      endcase
      write_reg(REG_HOLD_SAMPLES, val);
      case ((p == 0) ? 0 : $urandom_range(0, 9))
        0:       val = 0;
        1:       val = '1;
        2:       val = $urandom;
        default: val = STEP_UNITY + $urandom_range(0, 1 << 27);
      endcase
      write_reg(REG_ATTACK_GAIN, val);
      case ((p == 0) ? 1 : $urandom_range(0, 9))
        0:       val = 0;
        1:       val = '1;
        2:       val = $urandom;
        default: val = STEP_UNITY - $urandom_range(0, 1 << 28);
      endcase
      write_reg(REG_RELEASE_GAIN, val);
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE, (1 << CFG_INDEX_W) - 1)), $urandom);

      steady = (p == 2);
      if (p == 5) long_stall_req = 1'b1;
      quiet_pct = $urandom_range(40, 80);
      foreach (fav[k]) fav[k] = $urandom_range(0, NUM_CH - 1);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        gap = (!steady && p != 5 && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        ch  = ($urandom_range(0, 99) < 85) ? fav[$urandom_range(0, 2)]
                                           : 3'($urandom_range(0, NUM_CH - 1));
        push_sample(ch, draw_sample(quiet_pct), gap, 1'b0, '0);
      end
      steady = 1'b0;
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (!failed)
      $display("audio_noise_gate verification clean");
    else
      $display("audio_noise_gate verification failed");
    $finish;
  end

endmodule
